FILE: rtl/periodic_timer_bank_assert.svh
// Assertion macros used by the timer bank top level.
`ifndef PERIODIC_TIMER_BANK_ASSERT_SVH
`define PERIODIC_TIMER_BANK_ASSERT_SVH

`ifndef ASSERT_OFF

// Same-cycle implication.
`define PTB_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("timer bank check failed");

// Next-cycle implication.
`define PTB_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("timer bank check failed");

// Delayed implication, checked later than PTB_ASSERT_NEXT.
`define PTB_ASSERT_LATER(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> ##1 (cons)) \
      else $error("timer bank check failed");

`else

`define PTB_ASSERT_NOW(label, clk, rst, ante, cons)
`define PTB_ASSERT_NEXT(label, clk, rst, ante, cons)
`define PTB_ASSERT_LATER(label, clk, rst, ante, cons)

`endif

`endif

FILE: rtl/ptb_pkg.sv
// Types and constants of the periodic timer bank.
`timescale 1ns / 1ps

package ptb_pkg;

   localparam int NUM_TIMERS   = 16;
   localparam int ACTION_W     = 3;
   localparam int INDEX_W      = 4;
   localparam int PERIOD_W     = 16;
   localparam int FIRE_W       = 16;
   localparam int ELAPSED_W    = 32;
   // countdown holds -1 .. 2^PERIOD_W-2, and one tick of 10 below that
   localparam int COUNT_W      = PERIOD_W + 1;
   localparam int STEP_W       = 4;
   localparam int LONG_TICK_MS = 10;
   // wide enough to compare any channel number against an index
   localparam int CH_ID_W      = 7;

   typedef enum logic [ACTION_W-1:0] {
      ACT_TICK_1MS  = 3'd0,
      ACT_TICK_10MS = 3'd1,
      ACT_ENABLE    = 3'd2,
      ACT_DISABLE   = 3'd3,
      ACT_CONTINUE  = 3'd4,
      ACT_QUERY     = 3'd5
   } action_type;

   // broadcast from the decoder to every channel
   typedef struct packed {
      logic                tick;
      logic [STEP_W-1:0]   step;
      logic                load;
      logic                pause;
      logic                resume;
      logic [PERIOD_W-1:0] period;
   } chan_cmd_type;

endpackage

FILE: rtl/periodic_timer_bank.sv
// Top level of the periodic timer bank.
`timescale 1ns / 1ps
// Bank of periodic millisecond timers driven by one command channel.
// A beat is taken at each rising edge with start high and busy low; busy is
// always low, so a command may be issued in every cycle.
// Commands: 1 ms tick, 10 ms tick, enable (load period), disable, continue,
// query. Ticks advance the millisecond counter and every running channel in
// parallel; a channel that runs out sets its bit in rsp_fire_mask and reloads.
// Each command yields exactly one result beat: rsp_valid is high for one
// cycle, and a command's result passes the input register, then the result
// register, before it is taken. Throughput is one command per cycle, limited
// only by the single decode and update pass over all channels.
// The receiver has no way to stall; a result not taken in its cycle is lost.
// Synchronous reset stops all channels and clears periods, countdowns and
// the millisecond counter; nothing accepted before reset yields a result.
`include "periodic_timer_bank_assert.svh"

module periodic_timer_bank (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  logic [ptb_pkg::ACTION_W-1:0]   req_action,
   input  logic [ptb_pkg::INDEX_W-1:0]    req_timer_index,
   input  logic [ptb_pkg::PERIOD_W-1:0]   req_period_ms,
   output logic                           rsp_valid,
   output logic [ptb_pkg::FIRE_W-1:0]     rsp_fire_mask,
   output logic                           rsp_run_flag,
   output logic [ptb_pkg::ELAPSED_W-1:0]  rsp_elapsed_ms
);

   // input register
   logic                           in_valid_ff;
   logic [ptb_pkg::ACTION_W-1:0]   in_action_ff;
   logic [ptb_pkg::INDEX_W-1:0]    in_index_ff;
   logic [ptb_pkg::PERIOD_W-1:0]   in_period_ff;

   logic [ptb_pkg::ELAPSED_W-1:0]  elapsed_ff, elapsed_in;
   logic                           out_valid_ff;
   logic [ptb_pkg::FIRE_W-1:0]     out_fire_ff, out_fire_in;
   logic                           out_run_ff, out_run_in;

   ptb_pkg::chan_cmd_type          cmd;
   logic                           is_tick;
   logic [ptb_pkg::NUM_TIMERS-1:0] fire_vec;
   logic [ptb_pkg::NUM_TIMERS-1:0] run_sel_vec;

   assign busy = 1'b0;

   always_comb begin
      cmd        = '0;
      cmd.period = in_period_ff;
      if (in_valid_ff) begin
         unique case (ptb_pkg::action_type'(in_action_ff))
            ptb_pkg::ACT_TICK_1MS: begin
               cmd.tick = 1'b1;
               cmd.step = ptb_pkg::STEP_W'(1);
            end
            ptb_pkg::ACT_TICK_10MS: begin
               cmd.tick = 1'b1;
               cmd.step = ptb_pkg::STEP_W'(ptb_pkg::LONG_TICK_MS);
            end
            ptb_pkg::ACT_ENABLE:   cmd.load   = 1'b1;
            ptb_pkg::ACT_DISABLE:  cmd.pause  = 1'b1;
            ptb_pkg::ACT_CONTINUE: cmd.resume = 1'b1;
            default: ;  // query and unused codes change nothing
         endcase
      end
   end

   assign is_tick = cmd.tick;

   for (genvar n = 0; n < ptb_pkg::NUM_TIMERS; n++) begin : g_chan
      logic sel;
      logic run;
      assign sel = (ptb_pkg::CH_ID_W'(in_index_ff) == ptb_pkg::CH_ID_W'(n));
      ptb_channel u_chan (
         .clock (clock),
         .reset (reset),
         .cmd   (cmd),
         .sel   (sel),
         .fire  (fire_vec[n]),
         .run   (run)
      );
      assign run_sel_vec[n] = sel & run;
   end

   // each channel drives its own mask bit; any bit with no channel reads zero
   for (genvar b = 0; b < ptb_pkg::FIRE_W; b++) begin : g_mask
      if (b < ptb_pkg::NUM_TIMERS) begin : g_used
         assign out_fire_in[b] = fire_vec[b];
      end else begin : g_none
         assign out_fire_in[b] = 1'b0;
      end
   end

   assign out_run_in = |run_sel_vec;
   assign elapsed_in = elapsed_ff + ptb_pkg::ELAPSED_W'(cmd.step);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         elapsed_ff   <= '0;
      end else begin
         in_valid_ff  <= start & ~busy;
         out_valid_ff <= in_valid_ff;
         if (is_tick) begin
            elapsed_ff <= elapsed_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start && !busy) begin
         in_action_ff <= req_action;
         in_index_ff  <= req_timer_index;
         in_period_ff <= req_period_ms;
      end
      if (in_valid_ff) begin
         out_fire_ff <= out_fire_in;
         out_run_ff  <= out_run_in;
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_fire_mask  = out_fire_ff;
   assign rsp_run_flag   = out_run_ff;
   assign rsp_elapsed_ms = elapsed_ff;

   `PTB_ASSERT_LATER(a_rsp_follows_cmd, clock, reset, start && !busy, rsp_valid)
   `PTB_ASSERT_NEXT(a_no_fire_off_tick, clock, reset, in_valid_ff && !is_tick, rsp_fire_mask == '0)
   `PTB_ASSERT_NEXT(a_elapsed_hold, clock, reset, !is_tick, $stable(elapsed_ff))
   `PTB_ASSERT_NOW(a_tick_needs_cmd, clock, reset, is_tick, in_valid_ff)

endmodule

FILE: rtl/ptb_channel.sv
// One timer channel: reload period, countdown and run flag.
`timescale 1ns / 1ps

module ptb_channel (
   input  logic                 clock,
   input  logic                 reset,
   input  ptb_pkg::chan_cmd_type cmd,
   input  logic                 sel,
   output logic                 fire,
   output logic                 run
);

   logic [ptb_pkg::PERIOD_W-1:0] period_ff, period_in;
   logic [ptb_pkg::COUNT_W-1:0]  count_ff, count_in;
   logic                         run_ff, run_in;
   logic [ptb_pkg::COUNT_W-1:0]  count_dec;
   logic [ptb_pkg::COUNT_W-1:0]  count_reload;

   assign count_dec    = count_ff - ptb_pkg::COUNT_W'(cmd.step);
   assign count_reload = ptb_pkg::COUNT_W'(period_ff) - ptb_pkg::COUNT_W'(1);

   // sign bit of the decremented count marks expiry
   assign fire = cmd.tick & run_ff & count_dec[ptb_pkg::COUNT_W-1];

   always_comb begin
      period_in = period_ff;
      count_in  = count_ff;
      run_in    = run_ff;
      if (cmd.tick && run_ff) begin
         count_in = fire ? count_reload : count_dec;
      end
      if (sel && cmd.load) begin
         period_in = cmd.period;
         count_in  = ptb_pkg::COUNT_W'(cmd.period) - ptb_pkg::COUNT_W'(1);
         run_in    = 1'b1;
      end
      if (sel && cmd.pause) begin
         run_in = 1'b0;
      end
      if (sel && cmd.resume) begin
         run_in = 1'b1;
      end
   end

   assign run = run_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff <= '0;
         count_ff  <= '0;
         run_ff    <= 1'b0;
      end else begin
         period_ff <= period_in;
         count_ff  <= count_in;
         run_ff    <= run_in;
      end
   end

endmodule
